/* hw/rtl/pdap_pkg.sv */
// Shared types, constants and the arctangent table of the pose filter.
// Used by every file of the pose_deadband_average_polar block; depends on nothing.
package pdap_pkg;

  localparam int unsigned WindowDepth = 10;
  localparam int unsigned DataW       = 24;
  localparam int unsigned BandW       = 23;
  localparam int unsigned DirW        = 17;
  localparam int unsigned CfgW        = 24;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CntW        = $clog2(WindowDepth + 1);
  localparam int unsigned IdxW        = $clog2(WindowDepth);
  localparam int unsigned SumW        = DataW + CntW;
  localparam int unsigned DivNumW     = SumW + 1;
  localparam int unsigned DivDenW     = CntW + 1;
  localparam int unsigned SqW         = 2 * DataW;
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned StepW       = 5;
  localparam int unsigned CordicFracW = 16;
  localparam int unsigned CordicW     = DataW + CordicFracW + 4;
  localparam int unsigned AccW        = 27;
  localparam int unsigned DirLimit    = 46080;
  localparam int unsigned HalfTurn    = 180;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeadingBand = 2'd0,
    CfgXBand       = 2'd1,
    CfgYBand       = 2'd2,
    CfgLengthFloor = 2'd3
  } pdap_cfg_e;

  typedef enum logic [3:0] {
    StIdle,
    StSum,
    StDivStart,
    StDivWait,
    StSqX,
    StSqY,
    StSqAdd,
    StSqrtStart,
    StSqrtWait,
    StCordicInit,
    StCordic,
    StRound,
    StLoad
  } pdap_state_e;

  // Handshake status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } pdap_unit_sts_t;

  // atan(2^-i) in units of 2^-16 degree.
  function automatic logic [AccW-1:0] atan_step(input logic [StepW-1:0] i);
    logic [AccW-1:0] v;
    unique case (i)
      5'd0:    v = AccW'(2949120);
      5'd1:    v = AccW'(1740967);
      5'd2:    v = AccW'(919879);
      5'd3:    v = AccW'(466945);
      5'd4:    v = AccW'(234379);
      5'd5:    v = AccW'(117304);
      5'd6:    v = AccW'(58666);
      5'd7:    v = AccW'(29335);
      5'd8:    v = AccW'(14668);
      5'd9:    v = AccW'(7334);
      5'd10:   v = AccW'(3667);
      5'd11:   v = AccW'(1833);
      5'd12:   v = AccW'(917);
      5'd13:   v = AccW'(458);
      5'd14:   v = AccW'(229);
      5'd15:   v = AccW'(115);
      5'd16:   v = AccW'(57);
      5'd17:   v = AccW'(29);
      5'd18:   v = AccW'(14);
      5'd19:   v = AccW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/pose_deadband_average_polar.sv */
// Pose filter top level: dead band, windowed mean and polar conversion.
// Depends on pdap_pkg, pdap_div and pdap_sqrt.
//
// Usage: one pose item (heading, x, y) enters on the input channel when
// in_valid_i is high and in_stall_o is low. Each value below its dead band
// is zeroed and stored in its own window of ten entries; the windows give a
// mean (or zero when zeros are the majority), and the filtered x and y are
// turned into a direction in units of 2^-8 degree and a length. One result item leaves
// on the output channel per input item, held while out_stall_i is high.
// Processing runs in order: the windows are summed, each mean is divided in
// the shared bit-serial divider (a mean that is zero by majority skips it),
// x and y are squared in one multiplier, the square root unit gives the
// length, CORDIC steps give the direction (skipped when filtered x and y
// are both zero), and the result is rounded and loaded.
// The block takes one item at a time and is ready again in the cycle after
// the result is loaded.
// The output register lets a new item be taken while the last result still
// waits; the new result is loaded only once the old one has been taken.
// Reset clears the window fill count and the handshake state and restores
// the dead bands and the length floor to their defaults. The configuration
// port writes one register per cycle and is meant to be used while idle.
module pose_deadband_average_polar (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pdap_pkg::DataW-1:0]   heading_in_i,
  input  logic signed [pdap_pkg::DataW-1:0]   pos_x_in_i,
  input  logic signed [pdap_pkg::DataW-1:0]   pos_y_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pdap_pkg::DataW-1:0]   heading_out_o,
  output logic signed [pdap_pkg::DirW-1:0]    direction_out_o,
  output logic        [pdap_pkg::DataW-1:0]   length_out_o,
  input  logic                                cfg_we_i,
  input  logic [pdap_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pdap_pkg::CfgW-1:0]           cfg_data_i
);

  localparam int unsigned DataW   = pdap_pkg::DataW;
  localparam int unsigned CntW    = pdap_pkg::CntW;
  localparam int unsigned IdxW    = pdap_pkg::IdxW;
  localparam int unsigned SumW    = pdap_pkg::SumW;
  localparam int unsigned AccW    = pdap_pkg::AccW;
  localparam int unsigned CordicW = pdap_pkg::CordicW;
  localparam logic signed [AccW-1:0] HalfTurnAcc =
    AccW'(pdap_pkg::HalfTurn * (1 << pdap_pkg::CordicFracW));
  localparam logic signed [AccW-1:0] DirMax = AccW'(pdap_pkg::DirLimit);

  // Configuration registers.
  logic [pdap_pkg::BandW-1:0] heading_band_q, x_band_q, y_band_q;
  logic [DataW-1:0]           length_floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_band_q <= pdap_pkg::BandW'(256);
      x_band_q       <= pdap_pkg::BandW'(1792);
      y_band_q       <= pdap_pkg::BandW'(512);
      length_floor_q <= DataW'(2560);
    end else if (cfg_we_i) begin
      unique case (pdap_pkg::pdap_cfg_e'(cfg_idx_i))
        pdap_pkg::CfgHeadingBand: heading_band_q <= cfg_data_i[pdap_pkg::BandW-1:0];
        pdap_pkg::CfgXBand:       x_band_q       <= cfg_data_i[pdap_pkg::BandW-1:0];
        pdap_pkg::CfgYBand:       y_band_q       <= cfg_data_i[pdap_pkg::BandW-1:0];
        pdap_pkg::CfgLengthFloor: length_floor_q <= cfg_data_i[DataW-1:0];
        default: ;
      endcase
    end
  end

  // A value whose magnitude is below the band reads as zero.
  function automatic logic signed [DataW-1:0] dead_band(
    input logic signed [DataW-1:0]  v,
    input logic [pdap_pkg::BandW-1:0] band
  );
    logic [DataW-1:0] mag;
    mag = v[DataW-1] ? DataW'(-v) : DataW'(v);
    return (mag < {1'b0, band}) ? '0 : v;
  endfunction

  pdap_pkg::pdap_state_e state_q, state_d;

  logic accept, load_out, div_start, sqrt_start;
  logic sum_last, cur_majority_zero;

  // Window storage and bookkeeping.
  logic signed [DataW-1:0] h_win_q [pdap_pkg::WindowDepth];
  logic signed [DataW-1:0] x_win_q [pdap_pkg::WindowDepth];
  logic signed [DataW-1:0] y_win_q [pdap_pkg::WindowDepth];
  logic [CntW-1:0]         fill_q;
  logic [IdxW-1:0]         oldest_q, rd_idx_q, wr_slot;
  logic                    full;

  logic signed [SumW-1:0]  sum_q  [3];
  logic [CntW-1:0]         zero_q [3];
  logic signed [DataW-1:0] win_rd [3];
  logic [1:0]              ch_q;
  logic signed [DataW-1:0] filt_q [3];

  logic signed [SumW-1:0]        cur_sum;
  logic [SumW-1:0]               cur_abs;
  logic [pdap_pkg::DivNumW-1:0]  div_num, div_quo;
  logic [pdap_pkg::DivDenW-1:0]  div_den;
  logic [DataW-1:0]              div_q;
  pdap_pkg::pdap_unit_sts_t      div_sts, sqrt_sts;

  logic signed [DataW-1:0]       mul_op;
  logic signed [pdap_pkg::SqW-1:0] sq;
  logic [pdap_pkg::SqW-1:0]      prod_q, rad_q;
  logic [DataW-1:0]              root, len_q;

  logic signed [CordicW-1:0]     cx_q, cy_q, xs, ys, xe, ye;
  logic signed [AccW-1:0]        acc_q, at, acc_abs, rnd_mag, rnd_val;
  logic [pdap_pkg::StepW-1:0]    step_q;
  logic signed [pdap_pkg::DirW-1:0] dir_q;

  logic                          out_valid_q;
  logic signed [DataW-1:0]       heading_out_q;
  logic signed [pdap_pkg::DirW-1:0] direction_out_q;
  logic [DataW-1:0]              length_out_q;

  assign full    = fill_q == CntW'(pdap_pkg::WindowDepth);
  assign wr_slot = full ? oldest_q : fill_q[IdxW-1:0];

  assign win_rd[0] = h_win_q[rd_idx_q];
  assign win_rd[1] = x_win_q[rd_idx_q];
  assign win_rd[2] = y_win_q[rd_idx_q];
  assign sum_last  = (CntW'(rd_idx_q) + CntW'(1)) == fill_q;

  // Per-channel mean: floor((2|sum| + n) / 2n), sign restored afterwards.
  assign cur_sum           = sum_q[ch_q];
  assign cur_abs           = cur_sum[SumW-1] ? SumW'(-cur_sum) : SumW'(cur_sum);
  assign cur_majority_zero = {zero_q[ch_q], 1'b0} > {1'b0, fill_q};
  assign div_num           = {cur_abs, 1'b0} + pdap_pkg::DivNumW'(fill_q);
  assign div_den           = {fill_q, 1'b0};
  assign div_q             = div_quo[DataW-1:0];

  pdap_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .sts_o   (div_sts),
    .quo_o   (div_quo)
  );

  assign mul_op = (state_q == pdap_pkg::StSqX) ? filt_q[1] : filt_q[2];
  assign sq     = mul_op * mul_op;

  pdap_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad_q),
    .sts_o   (sqrt_sts),
    .root_o  (root)
  );

  // CORDIC vectoring step with floor shifts.
  assign xs  = cx_q >>> step_q;
  assign ys  = cy_q >>> step_q;
  assign at  = pdap_pkg::atan_step(step_q);
  assign xe  = {{(CordicW - DataW - pdap_pkg::CordicFracW){filt_q[1][DataW-1]}},
                filt_q[1], {pdap_pkg::CordicFracW{1'b0}}};
  assign ye  = {{(CordicW - DataW - pdap_pkg::CordicFracW){filt_q[2][DataW-1]}},
                filt_q[2], {pdap_pkg::CordicFracW{1'b0}}};

  // Round the angle to 2^-8 degree, ties away from zero, then clamp.
  assign acc_abs = acc_q[AccW-1] ? -acc_q : acc_q;
  assign rnd_mag = (acc_abs + AccW'(128)) >>> 8;
  assign rnd_val = acc_q[AccW-1] ? -rnd_mag : rnd_mag;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdap_pkg::StIdle:       if (in_valid_i) state_d = pdap_pkg::StSum;
      pdap_pkg::StSum:        if (sum_last) state_d = pdap_pkg::StDivStart;
      pdap_pkg::StDivStart: begin
        if (!cur_majority_zero) begin
          state_d = pdap_pkg::StDivWait;
        end else if (ch_q == 2'd2) begin
          state_d = pdap_pkg::StSqX;
        end
      end
      pdap_pkg::StDivWait: begin
        if (div_sts.done) begin
          state_d = (ch_q == 2'd2) ? pdap_pkg::StSqX : pdap_pkg::StDivStart;
        end
      end
      pdap_pkg::StSqX:        state_d = pdap_pkg::StSqY;
      pdap_pkg::StSqY:        state_d = pdap_pkg::StSqAdd;
      pdap_pkg::StSqAdd:      state_d = pdap_pkg::StSqrtStart;
      pdap_pkg::StSqrtStart:  state_d = pdap_pkg::StSqrtWait;
      pdap_pkg::StSqrtWait:   if (sqrt_sts.done) state_d = pdap_pkg::StCordicInit;
      pdap_pkg::StCordicInit: begin
        if (filt_q[1] == '0 && filt_q[2] == '0) begin
          state_d = pdap_pkg::StRound;
        end else begin
          state_d = pdap_pkg::StCordic;
        end
      end
      pdap_pkg::StCordic: begin
        if (step_q == pdap_pkg::StepW'(pdap_pkg::CordicSteps - 1)) begin
          state_d = pdap_pkg::StRound;
        end
      end
      pdap_pkg::StRound:      state_d = pdap_pkg::StLoad;
      pdap_pkg::StLoad:       if (!out_valid_q || !out_stall_i) state_d = pdap_pkg::StIdle;
      default:                state_d = pdap_pkg::StIdle;
    endcase
  end

  // Control strobes.
  always_comb begin
    in_stall_o = state_q != pdap_pkg::StIdle;
    accept     = in_valid_i && (state_q == pdap_pkg::StIdle);
    div_start  = (state_q == pdap_pkg::StDivStart) && !cur_majority_zero;
    sqrt_start = state_q == pdap_pkg::StSqrtStart;
    load_out   = (state_q == pdap_pkg::StLoad) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdap_pkg::StIdle;
      fill_q      <= '0;
      oldest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (full) begin
          oldest_q <= (oldest_q == IdxW'(pdap_pkg::WindowDepth - 1)) ? '0
                                                                     : oldest_q + IdxW'(1);
        end else begin
          fill_q <= fill_q + CntW'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Window writes: the three windows share one slot.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      h_win_q[wr_slot] <= dead_band(heading_in_i, heading_band_q);
      x_win_q[wr_slot] <= dead_band(pos_x_in_i, x_band_q);
      y_win_q[wr_slot] <= dead_band(pos_y_in_i, y_band_q);
    end
  end

  // Datapath registers, sequenced by the state.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pdap_pkg::StIdle: begin
        rd_idx_q <= '0;
        ch_q     <= '0;
        for (int c = 0; c < 3; c++) begin
          sum_q[c]  <= '0;
          zero_q[c] <= '0;
        end
      end
      pdap_pkg::StSum: begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
        for (int c = 0; c < 3; c++) begin
          sum_q[c]  <= sum_q[c] + {{CntW{win_rd[c][DataW-1]}}, win_rd[c]};
          zero_q[c] <= zero_q[c] + CntW'(win_rd[c] == '0);
        end
      end
      pdap_pkg::StDivStart: begin
        if (cur_majority_zero) begin
          filt_q[ch_q] <= '0;
          ch_q         <= ch_q + 2'd1;
        end
      end
      pdap_pkg::StDivWait: begin
        if (div_sts.done) begin
          filt_q[ch_q] <= cur_sum[SumW-1] ? -$signed(div_q) : $signed(div_q);
          ch_q         <= ch_q + 2'd1;
        end
      end
      pdap_pkg::StSqX: prod_q <= pdap_pkg::SqW'(sq);
      pdap_pkg::StSqY: begin
        rad_q  <= prod_q;
        prod_q <= pdap_pkg::SqW'(sq);
      end
      pdap_pkg::StSqAdd: rad_q <= rad_q + prod_q;
      pdap_pkg::StSqrtStart: ;
      pdap_pkg::StSqrtWait: begin
        if (sqrt_sts.done) begin
          len_q <= (root < length_floor_q) ? '0 : root;
        end
      end
      pdap_pkg::StCordicInit: begin
        step_q <= '0;
        if (filt_q[1][DataW-1]) begin
          cx_q  <= -xe;
          cy_q  <= -ye;
          acc_q <= filt_q[2][DataW-1] ? -HalfTurnAcc : HalfTurnAcc;
        end else begin
          cx_q  <= xe;
          cy_q  <= ye;
          acc_q <= '0;
        end
      end
      pdap_pkg::StCordic: begin
        step_q <= step_q + pdap_pkg::StepW'(1);
        if (cy_q[CordicW-1]) begin
          cx_q  <= cx_q - ys;
          cy_q  <= cy_q + xs;
          acc_q <= acc_q - at;
        end else begin
          cx_q  <= cx_q + ys;
          cy_q  <= cy_q - xs;
          acc_q <= acc_q + at;
        end
      end
      pdap_pkg::StRound: begin
        if (rnd_val > DirMax) begin
          dir_q <= pdap_pkg::DirW'(DirMax);
        end else if (rnd_val < -DirMax) begin
          dir_q <= pdap_pkg::DirW'(-DirMax);
        end else begin
          dir_q <= pdap_pkg::DirW'(rnd_val);
        end
      end
      pdap_pkg::StLoad: ;
      default: ;
    endcase
  end

  // Output register; the direction reads zero when length and heading are both zero.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      heading_out_q   <= filt_q[0];
      length_out_q    <= len_q;
      direction_out_q <= (len_q == '0 && filt_q[0] == '0) ? '0 : dir_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign heading_out_o   = heading_out_q;
  assign direction_out_o = direction_out_q;
  assign length_out_o    = length_out_q;

endmodule

/* hw/rtl/pdap_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pdap_pkg.
module pdap_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [pdap_pkg::DivNumW-1:0]       num_i,
  input  logic [pdap_pkg::DivDenW-1:0]       den_i,
  output pdap_pkg::pdap_unit_sts_t           sts_o,
  output logic [pdap_pkg::DivNumW-1:0]       quo_o
);

  localparam int unsigned CW = $clog2(pdap_pkg::DivNumW + 1);

  logic                             busy_q, done_q;
  logic [CW-1:0]                    cnt_q;
  logic [pdap_pkg::DivDenW-1:0]     rem_q, den_q, rem_d;
  logic [pdap_pkg::DivNumW-1:0]     quo_q;
  logic [pdap_pkg::DivDenW:0]       shifted, diff;
  logic                             fits;

  assign shifted = {rem_q, quo_q[pdap_pkg::DivNumW-1]};
  assign fits    = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};
  assign rem_d   = fits ? diff[pdap_pkg::DivDenW-1:0] : shifted[pdap_pkg::DivDenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(pdap_pkg::DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[pdap_pkg::DivNumW-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

/* hw/rtl/pdap_sqrt.sv */
// Digit-by-digit integer square root with round to nearest, two radicand bits per cycle.
// Depends on pdap_pkg.
module pdap_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pdap_pkg::SqW-1:0]       rad_i,
  output pdap_pkg::pdap_unit_sts_t       sts_o,
  output logic [pdap_pkg::DataW-1:0]     root_o
);

  localparam int unsigned Steps = pdap_pkg::SqW / 2;
  localparam int unsigned CW    = $clog2(Steps + 1);

  logic                          busy_q, done_q;
  logic [CW-1:0]                 cnt_q;
  logic [pdap_pkg::SqW-1:0]      r_q, bit_q, rem_q, tsum;
  logic                          ge;
  logic [pdap_pkg::DataW:0]      rnd;
  logic                          sat;

  assign tsum = r_q + bit_q;
  assign ge   = rem_q >= tsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(Steps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= '0;
      bit_q <= {2'b01, {(pdap_pkg::SqW - 2){1'b0}}};
      rem_q <= rad_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_q - tsum : rem_q;
      r_q   <= ge ? (r_q >> 1) + bit_q : r_q >> 1;
      bit_q <= bit_q >> 2;
    end
  end

  // Round up when the remainder exceeds the root, then saturate.
  assign rnd    = {1'b0, r_q[pdap_pkg::DataW-1:0]} + (pdap_pkg::DataW + 1)'(rem_q > r_q);
  assign sat    = rnd[pdap_pkg::DataW] | (|r_q[pdap_pkg::SqW-1:pdap_pkg::DataW]);
  assign root_o = sat ? '1 : rnd[pdap_pkg::DataW-1:0];

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

/* hw/rtl/pdap_checker.sv */
// Port-level checker for pose_deadband_average_polar, attached by a bind statement.
// Depends on pdap_pkg and the top level's port names.
module pdap_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [pdap_pkg::DataW-1:0]  heading_out_o,
  input logic signed [pdap_pkg::DirW-1:0]   direction_out_o,
  input logic        [pdap_pkg::DataW-1:0]  length_out_o
);

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a second item right after the first");

  // A result becomes valid only at the end of processing, never from idle.
  a_rise_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while the block was idle");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(heading_out_o) &&
      $stable(direction_out_o) && $stable(length_out_o))
    else $error("stalled result changed");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(direction_out_o) <= $signed(18'sd46080) &&
      $signed(direction_out_o) >= $signed(-18'sd46080))
    else $error("direction out of range");

  a_dir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_out_o == '0 && heading_out_o == '0 |-> direction_out_o == '0)
    else $error("direction not zero for an empty pose");

endmodule

bind pose_deadband_average_polar pdap_checker u_pdap_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for the pose filter: dead band, windowed mean, polar output.
// Predicts every result item in SystemVerilog and compares it field by field.
// Depends on pdap_pkg and pose_deadband_average_polar.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic signed [pdap_pkg::DataW-1:0] heading;
    logic signed [pdap_pkg::DataW-1:0] pos_x;
    logic signed [pdap_pkg::DataW-1:0] pos_y;
  } pose_t;

  typedef struct {
    logic signed [pdap_pkg::DataW-1:0] heading;
    logic signed [pdap_pkg::DirW-1:0]  direction;
    logic        [pdap_pkg::DataW-1:0] length;
  } polar_t;

  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [pdap_pkg::DataW-1:0] heading_in_i = '0;
  logic signed [pdap_pkg::DataW-1:0] pos_x_in_i = '0;
  logic signed [pdap_pkg::DataW-1:0] pos_y_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [pdap_pkg::DataW-1:0] heading_out_o;
  logic signed [pdap_pkg::DirW-1:0] direction_out_o;
  logic [pdap_pkg::DataW-1:0] length_out_o;
  logic cfg_we_i = 1'b0;
  logic [pdap_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [pdap_pkg::CfgW-1:0] cfg_data_i = '0;

  pose_deadband_average_polar dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: dead bands, floor and the three windows.
  longint band_h, band_x, band_y, floor_len;
  longint win_h[pdap_pkg::WindowDepth], win_x[pdap_pkg::WindowDepth];
  longint win_y[pdap_pkg::WindowDepth];
  int fill, oldest;

  pose_t pending_poses[$];
  polar_t expected_polar[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic longint zero_small(longint v, longint band);
    longint mag;
    mag = v < 0 ? -v : v;
    return mag < band ? 0 : v;
  endfunction

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -1 - ((-1 - v) >>> s);
  endfunction

  function automatic longint window_mean(longint w[pdap_pkg::WindowDepth], int n);
    int zeros;
    longint sum, mag, q;
    zeros = 0;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      if (w[i] == 0) zeros++;
      sum += w[i];
    end
    if (zeros > n - zeros) return 0;
    mag = sum < 0 ? -sum : sum;
    q = (mag * 2 + n) / (2 * n);
    return sum < 0 ? -q : q;
  endfunction

  function automatic longint round_sqrt(longint s);
    longint r, b, rem;
    r = 0;
    b = 64'sd1 << 62;
    rem = s;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r * r + r) r++;
    return r;
  endfunction

  // Vectoring CORDIC in units of 2^-16 degree, rounded to 2^-8.
  function automatic longint cordic_angle(longint x0, longint y0);
    longint x, y, acc, xs, ys, d;
    x = x0 * 65536;
    y = y0 * 65536;
    acc = 0;
    if (x0 == 0 && y0 == 0) return 0;
    if (x0 < 0) begin
      x = -x;
      y = -y;
      acc = (y0 >= 0 ? 1 : -1) * longint'(pdap_pkg::HalfTurn) * 65536;
    end
    for (int i = 0; i < pdap_pkg::CordicSteps; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y < 0) begin
        x -= ys;
        y += xs;
        acc -= longint'(pdap_pkg::atan_step(pdap_pkg::StepW'(i)));
      end else begin
        x += ys;
        y -= xs;
        acc += longint'(pdap_pkg::atan_step(pdap_pkg::StepW'(i)));
      end
    end
    d = acc >= 0 ? (acc + 128) >>> 8 : -((-acc + 128) >>> 8);
    if (d > longint'(pdap_pkg::DirLimit)) d = longint'(pdap_pkg::DirLimit);
    if (d < -longint'(pdap_pkg::DirLimit)) d = -longint'(pdap_pkg::DirLimit);
    return d;
  endfunction

  function automatic polar_t filter_pose(pose_t p);
    polar_t r;
    int slot;
    longint hf, xf, yf, len, dir;
    if (fill < pdap_pkg::WindowDepth) begin
      slot = fill;
      fill++;
    end else begin
      slot = oldest;
      oldest = (slot + 1 >= pdap_pkg::WindowDepth) ? 0 : slot + 1;
    end
    win_h[slot] = zero_small(longint'(p.heading), band_h);
    win_x[slot] = zero_small(longint'(p.pos_x), band_x);
    win_y[slot] = zero_small(longint'(p.pos_y), band_y);
    hf = window_mean(win_h, fill);
    xf = window_mean(win_x, fill);
    yf = window_mean(win_y, fill);
    len = round_sqrt(xf * xf + yf * yf);
    if (len > 64'hFFFFFF) len = 64'hFFFFFF;
    if (len < floor_len) len = 0;
    dir = cordic_angle(xf, yf);
    if (len == 0 && hf == 0) dir = 0;
    r.heading = pdap_pkg::DataW'(hf);
    r.direction = pdap_pkg::DirW'(dir);
    r.length = pdap_pkg::DataW'(len);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Random gap: mostly zero or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Driver: presents pending items, with random gaps between them.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_polar = {expected_polar, filter_pose(pending_poses.pop_front())};
        send_gap = gap_len();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_poses.size() > 0) begin
          in_valid_i <= 1'b1;
          heading_in_i <= pending_poses[0].heading;
          pos_x_in_i <= pending_poses[0].pos_x;
          pos_y_in_i <= pending_poses[0].pos_y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result items and drives a random stall.
  int stall_left = 0;
  always @(posedge clk_i) begin
    polar_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_polar.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          want = expected_polar.pop_front();
          if (heading_out_o !== want.heading)
            report_mismatch("heading", heading_out_o, want.heading);
          if (direction_out_o !== want.direction)
            report_mismatch("direction", direction_out_o, want.direction);
          if (length_out_o !== want.length)
            report_mismatch("length", length_out_o, want.length);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = gap_len();
        out_stall_i <= 1'b0;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(pdap_pkg::pdap_cfg_e idx, longint value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= pdap_pkg::CfgW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pdap_pkg::CfgHeadingBand: band_h = value & 64'h7FFFFF;
      pdap_pkg::CfgXBand:       band_x = value & 64'h7FFFFF;
      pdap_pkg::CfgYBand:       band_y = value & 64'h7FFFFF;
      default:                  floor_len = value & 64'hFFFFFF;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_poses.size() > 0 || in_valid_i || expected_polar.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_pose(longint h, longint x, longint y);
    pose_t p;
    p.heading = pdap_pkg::DataW'(h);
    p.pos_x = pdap_pkg::DataW'(x);
    p.pos_y = pdap_pkg::DataW'(y);
    pending_poses = {pending_poses, p};
  endtask

  // Values near a band, near zero, or anywhere in range.
  function automatic longint rand_value(longint band);
    int r;
    longint v;
    r = $urandom_range(0, 9);
    if (r < 4) v = $urandom_range(0, 2 * band + 4);
    else if (r < 6) v = 0;
    else if (r < 8) v = $urandom_range(0, 40000);
    else v = $urandom_range(0, 24'h7FFFFF);
    if ($urandom_range(0, 1)) v = -v;
    if (r == 9 && $urandom_range(0, 3) == 0) v = -64'sd8388608;
    return v;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      add_pose(rand_value(band_h), rand_value(band_x), rand_value(band_y));
    wait_drained();
  endtask

  initial begin
    band_h = 256;
    band_x = 1792;
    band_y = 512;
    floor_len = 2560;
    fill = 0;
    oldest = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, dead band edges, all quadrants, zero majority.
    add_pose(0, 0, 0);
    add_pose(8388607, 8388607, 8388607);
    add_pose(-8388608, -8388608, -8388608);
    add_pose(255, 1791, 511);
    add_pose(256, 1792, 512);
    add_pose(-256, -1792, -512);
    add_pose(1000, -5000, 0);
    add_pose(-1000, -5000, -3000);
    add_pose(0, 5000, -3000);
    add_pose(0, 0, 7000);
    add_pose(0, -9000, 0);
    add_pose(3000, 8388607, -8388608);
    add_pose(0, 0, 0);
    add_pose(0, 0, 0);
    add_pose(0, 0, 0);
    add_pose(0, 0, 0);
    add_pose(0, 0, 0);
    add_pose(0, 0, 0);
    add_pose(-3000, 2600, 0);
    add_pose(12345, -2600, 2600);
    wait_drained();

    write_reg(pdap_pkg::CfgHeadingBand, 0);
    write_reg(pdap_pkg::CfgXBand, 0);
    write_reg(pdap_pkg::CfgYBand, 0);
    write_reg(pdap_pkg::CfgLengthFloor, 0);
    random_phase(400);

    write_reg(pdap_pkg::CfgHeadingBand, 24'h7FFFFF);
    write_reg(pdap_pkg::CfgXBand, 24'h7FFFFF);
    write_reg(pdap_pkg::CfgYBand, 24'h7FFFFF);
    write_reg(pdap_pkg::CfgLengthFloor, 24'hFFFFFF);
    random_phase(150);

    write_reg(pdap_pkg::CfgHeadingBand, $urandom_range(0, 24'h7FFFFF));
    write_reg(pdap_pkg::CfgXBand, $urandom_range(0, 5000));
    write_reg(pdap_pkg::CfgYBand, $urandom_range(0, 5000));
    write_reg(pdap_pkg::CfgLengthFloor, $urandom_range(0, 20000));
    random_phase(600);

    write_reg(pdap_pkg::CfgHeadingBand, 256);
    write_reg(pdap_pkg::CfgXBand, 1792);
    write_reg(pdap_pkg::CfgYBand, 512);
    write_reg(pdap_pkg::CfgLengthFloor, 2560);
    random_phase(600);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
